FILE: hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and helpers for the text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;
    localparam int CELL_W      = 16;

    localparam logic [7:0] RESET_ATTR  = 8'h0F;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7F;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_CP,
        S_CP_TAIL,
        S_FILL,
        S_READ,
        S_POS,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_req;

    typedef struct packed {
        logic [10:0]       cursor_pos;
        logic [CELL_W-1:0] cell_value;
        logic              scrolled;
    } t_rsp;

    typedef struct packed {
        logic       step;
        logic       home;
        logic [7:0] char_code;
    } t_cur_cmd;

    function automatic logic is_printable(input logic [7:0] c);
        return c inside {[CH_PRINT_LO:CH_PRINT_HI]};
    endfunction

endpackage

FILE: hw/rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Screen cell memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int   DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [tcw_pkg::CELL_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [tcw_pkg::CELL_W-1:0] o_rdata
);

    logic [tcw_pkg::CELL_W-1:0] r_mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/tcw_cursor.sv
// ----------------------------------------------------------------------------
// tcw_cursor
// Cursor row and column, control-character stepping and linear position.
// ----------------------------------------------------------------------------
module tcw_cursor #(
    parameter int  COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int  ROWS    = tcw_pkg::ROWS_DEF,
    localparam int AW      = $clog2(COLUMNS * ROWS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcw_pkg::t_cur_cmd i_cmd,
    output logic              o_scroll,
    output logic [AW-1:0]     o_lin
);

    import tcw_pkg::*;

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [AW-1:0] r_lin;
    logic [CW:0]   col_w;
    logic [RW:0]   row_w;
    logic          scroll;

    always_comb begin
        col_w = {1'b0, r_col};
        row_w = {1'b0, r_row};
        case (i_cmd.char_code)
            CH_BS: begin
                if (r_col != '0) begin
                    col_w = {1'b0, r_col} - 1'b1;
                end
            end
            CH_TAB: col_w = ({1'b0, r_col} + (CW+1)'(8)) & ~(CW+1)'(7);
            CH_CR:  col_w = '0;
            CH_LF: begin
                col_w = '0;
                row_w = row_w + 1'b1;
            end
            default: begin
                if (is_printable(i_cmd.char_code)) begin
                    col_w = col_w + 1'b1;
                end
            end
        endcase
        // wrap past the last column
        if (col_w >= (CW+1)'(COLUMNS)) begin
            col_w = '0;
            row_w = row_w + 1'b1;
        end
        // running off the bottom clamps to the last row; caller scrolls
        scroll = (row_w >= (RW+1)'(ROWS));
        if (scroll) begin
            row_w = (RW+1)'(ROWS - 1);
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cmd.home) begin
            n_col = '0;
            n_row = '0;
        end else if (i_cmd.step) begin
            n_col = col_w[CW-1:0];
            n_row = row_w[RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_lin <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_lin <= AW'(r_row) * AW'(COLUMNS) + AW'(r_col);
        end
    end

    assign o_scroll = scroll;
    assign o_lin    = r_lin;

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_col) < COLUMNS) && (int'(r_row) < ROWS))
        else $error("cursor outside screen");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !i_cmd.home && o_scroll)
        |=> (int'(r_row) == ROWS - 1) && (r_col == '0))
        else $error("scroll did not leave cursor at start of bottom row");

    a_lin_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($stable(r_row) && $stable(r_col))
        |-> (r_lin == AW'(r_row) * AW'(COLUMNS) + AW'(r_col)))
        else $error("linear position out of step with cursor");

endmodule

FILE: hw/rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Request sequencer: sweep counter for clear/scroll/reset fill, cell writes,
// reads and the result register.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
    parameter int  COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int  ROWS    = tcw_pkg::ROWS_DEF,
    localparam int AW      = $clog2(COLUMNS * ROWS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  tcw_pkg::t_req              i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output tcw_pkg::t_rsp              o_out,
    input  logic [7:0]                 i_attr,
    output logic                       o_mem_we,
    output logic [AW-1:0]              o_mem_waddr,
    output logic [tcw_pkg::CELL_W-1:0] o_mem_wdata,
    output logic                       o_mem_re,
    output logic [AW-1:0]              o_mem_raddr,
    input  logic [tcw_pkg::CELL_W-1:0] i_mem_rdata,
    output tcw_pkg::t_cur_cmd          o_cur_cmd,
    input  logic                       i_cur_scroll,
    input  logic [AW-1:0]              i_cur_lin
);

    import tcw_pkg::*;

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int FILL_START = (ROWS - 1) * COLUMNS;
    localparam int IW         = ((AW > 11) ? AW : 11) + 1;

    t_state        r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    t_req          r_req, n_req;
    logic          r_rd_ok, n_rd_ok;
    logic          r_scrolled, n_scrolled;
    logic          r_cp_vld, n_cp_vld;
    logic [AW-1:0] r_cp_dst, n_cp_dst;
    t_rsp          r_out, n_out;
    logic          r_out_vld, n_out_vld;

    logic          accept;
    logic          idx_ok;
    logic          cnt_last;
    logic          out_free;
    logic [CELL_W-1:0] blank;

    assign accept   = (r_state == S_IDLE) && i_in_valid;
    assign idx_ok   = IW'(i_in.cell_index) < IW'(CELLS);
    assign cnt_last = (r_cnt == AW'(CELLS - 1));
    assign out_free = !r_out_vld || i_out_ready;
    assign blank    = {((r_state == S_INIT) ? RESET_ATTR : i_attr), CH_SPACE};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_in.operation)
                        OP_PUT:   n_state = S_PUT;
                        OP_CLEAR: n_state = S_FILL;
                        OP_READ:  n_state = idx_ok ? S_READ : S_DONE;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_PUT:     n_state = i_cur_scroll ? S_CP : S_POS;
            S_CP: begin
                if (cnt_last) begin
                    n_state = S_CP_TAIL;
                end
            end
            S_CP_TAIL: n_state = S_FILL;
            S_FILL: begin
                if (cnt_last) begin
                    n_state = S_POS;
                end
            end
            S_READ:    n_state = S_DONE;
            S_POS:     n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // state outputs: memory port, cursor command, ready
    always_comb begin
        o_in_ready          = 1'b0;
        o_mem_we            = 1'b0;
        o_mem_waddr         = r_cnt;
        o_mem_wdata         = blank;
        o_mem_re            = 1'b0;
        o_mem_raddr         = r_cnt;
        o_cur_cmd.step      = 1'b0;
        o_cur_cmd.home      = 1'b0;
        o_cur_cmd.char_code = r_req.char_code;
        case (r_state)
            S_INIT: o_mem_we = 1'b1;
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (accept && (i_in.operation == OP_CLEAR)) begin
                    o_cur_cmd.home = 1'b1;
                end
            end
            S_PUT: begin
                o_cur_cmd.step = 1'b1;
                if (is_printable(r_req.char_code)) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = i_cur_lin;
                    o_mem_wdata = {i_attr, r_req.char_code};
                end
            end
            S_CP, S_CP_TAIL: begin
                o_mem_re = (r_state == S_CP);
                // write back the row below in the cycle after its read
                if (r_cp_vld) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_cp_dst;
                    o_mem_wdata = i_mem_rdata;
                end
            end
            S_FILL: o_mem_we = 1'b1;
            S_READ: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = AW'(r_req.cell_index);
            end
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        n_cnt      = r_cnt;
        n_req      = r_req;
        n_rd_ok    = r_rd_ok;
        n_scrolled = r_scrolled;
        n_cp_vld   = (r_state == S_CP);
        n_cp_dst   = r_cnt - AW'(COLUMNS);
        n_out      = r_out;
        n_out_vld  = r_out_vld;

        case (r_state)
            S_INIT, S_CP, S_FILL: n_cnt = r_cnt + 1'b1;
            S_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    n_req      = i_in;
                    n_rd_ok    = idx_ok;
                    n_scrolled = 1'b0;
                end
            end
            S_PUT: begin
                n_cnt      = AW'(COLUMNS);
                n_scrolled = i_cur_scroll;
            end
            S_CP_TAIL: n_cnt = AW'(FILL_START);
            default: ;
        endcase

        if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
        if ((r_state == S_DONE) && out_free) begin
            n_out_vld            = 1'b1;
            n_out.cursor_pos     = 11'(i_cur_lin);
            n_out.cell_value     = ((r_req.operation == OP_READ) && r_rd_ok) ?
                                   i_mem_rdata : '0;
            n_out.scrolled       = r_scrolled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_cnt     <= '0;
            r_cp_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_cp_vld  <= n_cp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_rd_ok    <= n_rd_ok;
        r_scrolled <= n_scrolled;
        r_cp_dst   <= n_cp_dst;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    a_copy_dst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_vld |-> (r_cp_dst < AW'(FILL_START)))
        else $error("scroll copy wrote into the bottom row");

    a_copy_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL || r_state == S_IDLE || r_state == S_INIT) |-> !r_cp_vld)
        else $error("scroll copy still pending");

    a_copy_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CP_TAIL) |-> (r_cp_vld && (r_cp_dst == AW'(FILL_START - 1))))
        else $error("last scroll copy misplaced");

endmodule

FILE: hw/rtl/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text console of COLUMNS x ROWS attribute/character cells with a cursor.
// ----------------------------------------------------------------------------
// Requests arrive on i_in (valid/ready): put character, clear screen or read
// cell. Each request returns one result on o_out (valid/ready) with the
// linear cursor position, the cell read (zero for other requests) and a
// scroll flag. i_cfg_we/i_cfg_wdata load the attribute byte at any edge.
// State sequence from accept to result valid, with the result register free:
//   put without scroll: S_PUT, S_POS, S_DONE (input ready again in the same cycle)
//   read in range: S_READ, S_DONE; out of range or unused code: S_DONE only
//   put with scroll: row copy (S_CP, S_CP_TAIL), bottom-row fill (S_FILL)
//   clear: S_FILL sweep of every cell, then S_POS, S_DONE
// All sweeps run through the single screen memory, one cell a cycle.
// After reset all COLUMNS*ROWS cells (2000 by default) are filled with
// blanks of attribute 0x0F while i_in is not ready.
// When the receiver stalls, one result waits in the output register; the
// next request is still taken and processed, and its result holds inside
// until the register frees.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tcw_pkg::t_req i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tcw_pkg::t_rsp o_out,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata
);

    import tcw_pkg::*;

    localparam int AW = $clog2(COLUMNS * ROWS);

    logic [7:0]        r_attr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;
    t_cur_cmd          cur_cmd;
    logic              cur_scroll;
    logic [AW-1:0]     cur_lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= RESET_ATTR;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_wdata;
        end
    end

    tcw_ram #(
        .DEPTH (COLUMNS * ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cur_cmd),
        .o_scroll (cur_scroll),
        .o_lin    (cur_lin)
    );

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out),
        .i_attr       (r_attr),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata),
        .o_cur_cmd    (cur_cmd),
        .i_cur_scroll (cur_scroll),
        .i_cur_lin    (cur_lin)
    );

endmodule

FILE: tb/text_console_char_writer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_test
// Self-checking bench for the text console character writer. A short table
// of directed requests covers field extremes, control bytes, clear and
// out-of-range reads. Random sequences of text lines, tab, backspace and
// line-feed runs, and cell reads follow, driving the cursor into wrap and
// scroll. A behavioral screen model predicts each result the table does not
// give. Both handshakes idle in random bursts. One long receiver hold-off
// backs the block up. The attribute register is swept between phases.
// ----------------------------------------------------------------------------
module text_console_char_writer_test;
    import tcw_pkg::*;

    localparam int COLS            = COLUMNS_DEF;
    localparam int ROWS            = ROWS_DEF;
    localparam int CELLS           = COLS * ROWS;
    localparam int RANDOM_ITEMS    = 1900;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int TAIL_CYCLES     = 50;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind  kind;
        t_req       req;
        logic [7:0] attr;
        bit         typed;
        t_rsp       rsp;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_req       i_in        = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_rsp       o_out;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_wdata = '0;

    // screen model
    logic [15:0] screen_mem [CELLS];
    int          cur_col;
    int          cur_row;
    logic [7:0]  cur_attr;

    t_rsp      pending_rsp[$];
    t_stim_row stim_rows[$];
    int        items_sent     = 0;
    int        quiet_cycles   = 0;
    bit        failed         = 1'b0;
    bit        sender_gaps_on = 1'b1;
    bit        sink_stalls_on = 1'b1;
    bit        hold_req       = 1'b0;

    text_console_char_writer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Advance the screen model by one request and return its result.
    function automatic t_rsp console_step(input t_req r);
        t_rsp        res;
        logic        scr;
        logic [15:0] blank;
        res   = '0;
        scr   = 1'b0;
        blank = {cur_attr, CH_SPACE};
        if (r.operation == OP_PUT) begin
            if (r.char_code == CH_BS) begin
                if (cur_col != 0)
                    cur_col--;
            end else if (r.char_code == CH_TAB) begin
                cur_col = (cur_col + 8) & ~7;
            end else if (r.char_code == CH_CR) begin
                cur_col = 0;
            end else if (r.char_code == CH_LF) begin
                cur_col = 0;
                cur_row++;
            end else if (r.char_code >= CH_PRINT_LO && r.char_code <= CH_PRINT_HI) begin
                screen_mem[cur_row * COLS + cur_col] = {cur_attr, r.char_code};
                cur_col++;
            end
            if (cur_col >= COLS) begin
                cur_col = 0;
                cur_row++;
            end
            if (cur_row >= ROWS) begin
                for (int i = 0; i < CELLS - COLS; i++)
                    screen_mem[i] = screen_mem[i + COLS];
                for (int i = CELLS - COLS; i < CELLS; i++)
                    screen_mem[i] = blank;
                cur_row = ROWS - 1;
                scr     = 1'b1;
            end
        end else if (r.operation == OP_CLEAR) begin
            for (int i = 0; i < CELLS; i++)
                screen_mem[i] = blank;
            cur_col = 0;
            cur_row = 0;
        end else if (r.operation == OP_READ) begin
            if (r.cell_index < CELLS)
                res.cell_value = screen_mem[r.cell_index];
        end
        res.cursor_pos = 11'(cur_row * COLS + cur_col);
        res.scrolled   = scr;
        return res;
    endfunction

    function automatic t_req make_req(input logic [1:0] op, input logic [7:0] ch,
                                      input logic [10:0] idx);
        t_req r;
        r.operation  = op;
        r.char_code  = ch;
        r.cell_index = idx;
        return r;
    endfunction

    function automatic t_stim_row dreq(input logic [1:0] op, input logic [7:0] ch,
                                       input logic [10:0] idx, input bit typed,
                                       input logic [10:0] pos, input logic [15:0] val);
        t_stim_row row;
        row.kind           = ROW_REQ;
        row.req            = make_req(op, ch, idx);
        row.attr           = '0;
        row.typed          = typed;
        row.rsp.cursor_pos = pos;
        row.rsp.cell_value = val;
        row.rsp.scrolled   = 1'b0;
        return row;
    endfunction

    function automatic t_stim_row dcfg(input logic [7:0] attr);
        t_stim_row row;
        row       = dreq(OP_PUT, 8'h00, 11'd0, 1'b0, 11'd0, 16'h0000);
        row.kind  = ROW_CFG;
        row.attr  = attr;
        return row;
    endfunction

    task automatic send_req(input t_req r, input t_rsp want);
        bit moves;
        if (sender_gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= r;
        do @(posedge i_clk); while (!o_in_ready);
        pending_rsp.push_back(want);
        moves = r.char_code == CH_BS || r.char_code == CH_TAB || r.char_code == CH_CR
             || r.char_code == CH_LF
             || (r.char_code >= CH_PRINT_LO && r.char_code <= CH_PRINT_HI);
        // ignored bytes and the unused code do not count toward the item total
        if (r.operation != OP_UNUSED && !(r.operation == OP_PUT && !moves))
            items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_attr(input logic [7:0] attr);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= attr;
        cur_attr     = attr;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_segment();
        t_req r;
        int   kind;
        int   n;
        int   sel;
        int   pos;
        int   idx;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            // a line of text, usually ended by a line feed
            n = $urandom_range(1, 90);
            repeat (n) begin
                r = make_req(OP_PUT, 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)),
                             11'($urandom));
                send_req(r, console_step(r));
            end
            sel = $urandom_range(0, 3);
            if (sel == 2) begin
                r = make_req(OP_PUT, CH_CR, 11'($urandom));
                send_req(r, console_step(r));
            end
            if (sel != 3) begin
                r = make_req(OP_PUT, CH_LF, 11'($urandom));
                send_req(r, console_step(r));
            end
        end else if (kind < 63) begin
            n = $urandom_range(1, kind < 55 ? 12 : 8);
            repeat (n) begin
                r = make_req(OP_PUT, kind < 55 ? CH_TAB : CH_BS, 11'($urandom));
                send_req(r, console_step(r));
            end
        end else if (kind < 73) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                r = make_req(OP_PUT, $urandom_range(0, 3) == 0 ? CH_CR : CH_LF,
                             11'($urandom));
                send_req(r, console_step(r));
            end
        end else if (kind < 88) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                sel = $urandom_range(0, 9);
                pos = cur_row * COLS + cur_col;
                if (sel < 5)
                    idx = $urandom_range(0, CELLS - 1);
                else if (sel < 8)
                    idx = (pos > 80) ? pos - $urandom_range(0, 80) : $urandom_range(0, pos);
                else
                    idx = $urandom_range(CELLS, 2047);
                r = make_req(OP_READ, 8'($urandom), 11'(idx));
                send_req(r, console_step(r));
            end
        end else if (kind < 96) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                r = make_req($urandom_range(0, 1) ? OP_UNUSED : OP_PUT, 8'($urandom),
                             11'($urandom));
                send_req(r, console_step(r));
            end
        end else if (kind < 98) begin
            r = make_req(OP_CLEAR, 8'($urandom), 11'($urandom));
            send_req(r, console_step(r));
        end else begin
            // write one character, then read it back
            pos = cur_row * COLS + cur_col;
            r = make_req(OP_PUT, 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)),
                         11'($urandom));
            send_req(r, console_step(r));
            r = make_req(OP_READ, 8'($urandom), 11'(pos));
            send_req(r, console_step(r));
        end
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, o_out);
                failed = 1'b1;
            end else begin
                want = pending_rsp.pop_front();
                if (o_out.cursor_pos !== want.cursor_pos) begin
                    $display("%0t: cursor_pos expected %0d actual %0d", $time,
                             want.cursor_pos, o_out.cursor_pos);
                    failed = 1'b1;
                end
                if (o_out.cell_value !== want.cell_value) begin
                    $display("%0t: cell_value expected %h actual %h", $time,
                             want.cell_value, o_out.cell_value);
                    failed = 1'b1;
                end
                if (o_out.scrolled !== want.scrolled) begin
                    $display("%0t: scrolled expected %b actual %b", $time,
                             want.scrolled, o_out.scrolled);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : main
        t_rsp       want;
        logic [7:0] attr_sel;
        int         target;

        cur_attr = RESET_ATTR;
        cur_col  = 0;
        cur_row  = 0;
        for (int i = 0; i < CELLS; i++)
            screen_mem[i] = {RESET_ATTR, CH_SPACE};

        stim_rows.push_back(dreq(OP_READ,   8'hFF,       11'd0,    1, 11'd0,  16'h0F20));
        stim_rows.push_back(dreq(OP_READ,   8'h00,       11'd1999, 1, 11'd0,  16'h0F20));
        stim_rows.push_back(dreq(OP_READ,   8'hFF,       11'h7FF,  1, 11'd0,  16'h0000));
        stim_rows.push_back(dreq(OP_UNUSED, 8'hFF,       11'h7FF,  1, 11'd0,  16'h0000));
        stim_rows.push_back(dreq(OP_PUT,    8'h41,       11'h7FF,  1, 11'd1,  16'h0000));
        stim_rows.push_back(dreq(OP_READ,   8'h00,       11'd0,    1, 11'd1,  16'h0F41));
        stim_rows.push_back(dreq(OP_PUT,    CH_BS,       11'd0,    1, 11'd0,  16'h0000));
        stim_rows.push_back(dreq(OP_PUT,    CH_BS,       11'h7FF,  1, 11'd0,  16'h0000));
        stim_rows.push_back(dreq(OP_PUT,    CH_TAB,      11'd0,    1, 11'd8,  16'h0000));
        stim_rows.push_back(dreq(OP_PUT,    CH_PRINT_HI, 11'd0,    1, 11'd9,  16'h0000));
        stim_rows.push_back(dreq(OP_PUT,    8'h1F,       11'd0,    1, 11'd9,  16'h0000));
        stim_rows.push_back(dreq(OP_PUT,    8'h80,       11'd0,    1, 11'd9,  16'h0000));
        stim_rows.push_back(dreq(OP_PUT,    8'hFF,       11'h7FF,  1, 11'd9,  16'h0000));
        stim_rows.push_back(dreq(OP_PUT,    8'h00,       11'd0,    1, 11'd9,  16'h0000));
        stim_rows.push_back(dreq(OP_PUT,    CH_CR,       11'd0,    1, 11'd0,  16'h0000));
        stim_rows.push_back(dreq(OP_PUT,    CH_LF,       11'd0,    1, 11'd80, 16'h0000));
        stim_rows.push_back(dcfg(8'h00));
        stim_rows.push_back(dreq(OP_PUT,    CH_SPACE,    11'd0,    1, 11'd81, 16'h0000));
        stim_rows.push_back(dreq(OP_READ,   8'h00,       11'd80,   1, 11'd81, 16'h0020));
        stim_rows.push_back(dcfg(8'hFF));
        stim_rows.push_back(dreq(OP_PUT,    8'h7E,       11'd5,    0, 11'd0,  16'h0000));
        stim_rows.push_back(dreq(OP_READ,   8'h55,       11'd81,   0, 11'd0,  16'h0000));
        stim_rows.push_back(dreq(OP_CLEAR,  8'hFF,       11'h7FF,  1, 11'd0,  16'h0000));
        stim_rows.push_back(dreq(OP_READ,   8'h00,       11'd81,   1, 11'd0,  16'hFF20));
        stim_rows.push_back(dreq(OP_PUT,    CH_TAB,      11'd0,    0, 11'd0,  16'h0000));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // hold off until the power-up screen fill is over
        do @(posedge i_clk); while (!o_in_ready);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CFG) begin
                write_attr(stim_rows[i].attr);
            end else begin
                want = console_step(stim_rows[i].req);
                send_req(stim_rows[i].req, stim_rows[i].typed ? stim_rows[i].rsp : want);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                1:       attr_sel = 8'h00;
                2:       attr_sel = 8'hFF;
                default: attr_sel = 8'($urandom_range(1, 254));
            endcase
            write_attr(attr_sel);
            sender_gaps_on = (ph != 3);
            sink_stalls_on = (ph != 3);
            if (ph == 2)
                hold_req = 1'b1;
            target = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < target)
                random_segment();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
